@@ rtl/mstc_pkg.sv @@
// Shared constants, codes and controller/datapath interface types
// for the mean/std color transfer block. No dependencies.
`default_nettype none

package mstc_pkg;

    localparam int CHANNELS       = 3;
    localparam int NCH            = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int LANES          = 3;
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int MAX_PIXELS     = 1048576;

    localparam int SUM_W  = 36;
    localparam int SQ_W   = 52;
    localparam int CNT_W  = 21;
    localparam int LIM_W  = 26;
    localparam int GAIN_W = 32;
    localparam int OFF_W  = 40;
    localparam int PROD_W = 88;   // shift-add multiplier product
    localparam int MPLR_W = 36;   // multiplier operand, one bit per step
    localparam int P1_W   = 73;   // n * sum of squares
    localparam int D_W    = 74;   // spread, padded to whole bit pairs
    localparam int ROOT_W = 37;
    localparam int SREM_W = 38;
    localparam int NUM_W  = 72;   // divider numerator and quotient
    localparam int DVS_W  = 40;
    localparam int STEP_W = 7;
    localparam int MAPP_W = GAIN_W + SAMPLE_BITS;
    localparam int V_W    = MAPP_W + 2;
    localparam int CH_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_ACC  = 2'd0,
        REQ_MAP  = 2'd1,
        REQ_CLR  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FLAT  = 2'd2
    } t_fit_st;

    typedef enum logic [2:0] {
        OP_MUL_NSQ = 3'd0,
        OP_MUL_SS  = 3'd1,
        OP_SQRT    = 3'd2,
        OP_DIV_G   = 3'd3,
        OP_MUL_GS  = 3'd4,
        OP_DIV_O   = 3'd5
    } t_op;

    typedef struct packed {
        logic            take;
        logic            start;
        t_op             op;
        logic            side_ref;
        logic [CH_W-1:0] ch;
        logic            fit_init;
        logic            set_flat;
        logic            map_mul;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic            done;
        logic            map_ready;
        logic            n_zero;
        logic            sb_zero;
        logic [CH_W-1:0] act;
        logic            out_busy;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/mean_std_color_transfer.sv @@
// Accumulate and clear transactions retire in the accept cycle, so the
// block stays ready for the next one. A map with a current fit passes the
// product stage and the output stage, which waits while an earlier result stalls.
// The first map after new statistics refits each active channel on the
// bit-serial multiplier (36), square root (37) and divider (72 steps)
// shared by all channels. Reset: synchronous, active low.
// Top level: ties the sequencer to the datapath. Depends on mstc_pkg,
// mstc_ctrl and mstc_dp.
`default_nettype none

module mean_std_color_transfer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: active channel count
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_a_ch0,
    input  logic [15:0] i_a_ch1,
    input  logic [15:0] i_a_ch2,
    input  logic [15:0] i_b_ch0,
    input  logic [15:0] i_b_ch1,
    input  logic [15:0] i_b_ch2,
    input  logic        i_pixel_valid,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_ch0,
    output logic [15:0] o_out_ch1,
    output logic [15:0] o_out_ch2,
    output logic [1:0]  o_map_status,
    output logic        o_clipped
);
    import mstc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: one transaction at a time. Accumulates retire in the
    // accept cycle; a map either goes straight to the product stage or
    // first walks the per-channel fit (spread, sqrt, gain, offset).
    mstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: sums, iterative arithmetic, gain/offset store and the
    // output register, which holds a result while the consumer stalls.
    mstc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_type    (i_req_type),
        .i_a_ch0       (i_a_ch0),
        .i_a_ch1       (i_a_ch1),
        .i_a_ch2       (i_a_ch2),
        .i_b_ch0       (i_b_ch0),
        .i_b_ch1       (i_b_ch1),
        .i_b_ch2       (i_b_ch2),
        .i_pixel_valid (i_pixel_valid),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_ch0     (o_out_ch0),
        .o_out_ch1     (o_out_ch1),
        .o_out_ch2     (o_out_ch2),
        .o_map_status  (o_map_status),
        .o_clipped     (o_clipped)
    );

endmodule

`default_nettype wire

@@ rtl/mstc_ctrl.sv @@
// Sequencer for the fit and map flow: accepts transactions and steps the
// datapath's iterative units. Depends on mstc_pkg.
`default_nettype none

module mstc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_req_type,
    output logic            o_in_ready,
    input  mstc_pkg::t_stat i_stat,
    output mstc_pkg::t_cmd  o_cmd
);
    import mstc_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_FIT_INIT = 12'b0000_0000_0010,
        S_MUL_A    = 12'b0000_0000_0100,
        S_MUL_B    = 12'b0000_0000_1000,
        S_SQRT     = 12'b0000_0001_0000,
        S_CHK      = 12'b0000_0010_0000,
        S_DIV_G    = 12'b0000_0100_0000,
        S_MUL_C    = 12'b0000_1000_0000,
        S_DIV_O    = 12'b0001_0000_0000,
        S_NEXT     = 12'b0010_0000_0000,
        S_MAP_MUL  = 12'b0100_0000_0000,
        S_MAP_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;
    logic            r_side, n_side;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_side  = r_side;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (t_req'(i_req_type) == REQ_MAP) begin
                        n_state = i_stat.map_ready ? S_MAP_MUL : S_FIT_INIT;
                    end
                end
            end
            S_FIT_INIT: begin
                o_cmd.fit_init = 1'b1;
                n_ch    = '0;
                n_side  = 1'b0;
                n_state = i_stat.n_zero ? S_MAP_MUL : S_MUL_A;
            end
            S_MUL_A: if (i_stat.done) n_state = S_MUL_B;
            S_MUL_B: if (i_stat.done) n_state = S_SQRT;
            S_SQRT:  if (i_stat.done) n_state = S_CHK;
            S_CHK: begin
                if (r_side) begin
                    n_state = S_DIV_G;
                end else if (i_stat.sb_zero) begin
                    o_cmd.set_flat = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_side  = 1'b1;
                    n_state = S_MUL_A;
                end
            end
            S_DIV_G: if (i_stat.done) n_state = S_MUL_C;
            S_MUL_C: if (i_stat.done) n_state = S_DIV_O;
            S_DIV_O: if (i_stat.done) n_state = S_NEXT;
            S_NEXT: begin
                if (r_ch == i_stat.act - 1'b1) begin
                    n_state = S_MAP_MUL;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_side  = 1'b0;
                    n_state = S_MUL_A;
                end
            end
            S_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state = S_MAP_OUT;
            end
            S_MAP_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // unit start on entry into an arithmetic state
        o_cmd.side_ref = n_side;
        o_cmd.ch       = n_ch;
        o_cmd.op       = OP_MUL_NSQ;
        case (n_state)
            S_MUL_A: o_cmd.op = OP_MUL_NSQ;
            S_MUL_B: o_cmd.op = OP_MUL_SS;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_DIV_G: o_cmd.op = OP_DIV_G;
            S_MUL_C: o_cmd.op = OP_MUL_GS;
            S_DIV_O: o_cmd.op = OP_DIV_O;
            default: o_cmd.op = OP_MUL_NSQ;
        endcase
        o_cmd.start = (n_state != r_state) &&
                      (n_state == S_MUL_A || n_state == S_MUL_B || n_state == S_SQRT ||
                       n_state == S_DIV_G || n_state == S_MUL_C || n_state == S_DIV_O);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_side  <= n_side;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mstc_dp.sv @@
// Datapath: statistics accumulators, iterative multiplier, square root and
// divider for the fit, gain/offset store, map arithmetic and output register.
// Depends on mstc_pkg.
`default_nettype none

module mstc_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_wdata,
    input  mstc_pkg::t_cmd         i_cmd,
    output mstc_pkg::t_stat        o_stat,
    input  logic [1:0]             i_req_type,
    input  logic [15:0]            i_a_ch0,
    input  logic [15:0]            i_a_ch1,
    input  logic [15:0]            i_a_ch2,
    input  logic [15:0]            i_b_ch0,
    input  logic [15:0]            i_b_ch1,
    input  logic [15:0]            i_b_ch2,
    input  logic                   i_pixel_valid,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [15:0]            o_out_ch0,
    output logic [15:0]            o_out_ch1,
    output logic [15:0]            o_out_ch2,
    output logic [1:0]             o_map_status,
    output logic                   o_clipped
);
    import mstc_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SMASK  = '1;
    localparam logic [GAIN_W-1:0]      GONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [NUM_W-1:0]       OFFLIM = NUM_W'(1) << (OFF_W - 1);
    localparam logic [V_W-1:0]         VHALF  = V_W'(1) << (GAIN_FRAC_BITS - 1);

    // lane views of the input ports
    logic [SAMPLE_BITS-1:0]   w_a   [LANES];
    logic [SAMPLE_BITS-1:0]   w_b   [LANES];
    logic [2*SAMPLE_BITS-1:0] w_asq [LANES];
    logic [2*SAMPLE_BITS-1:0] w_bsq [LANES];

    assign w_a[0] = i_a_ch0[SAMPLE_BITS-1:0];
    assign w_a[1] = i_a_ch1[SAMPLE_BITS-1:0];
    assign w_a[2] = i_a_ch2[SAMPLE_BITS-1:0];
    assign w_b[0] = i_b_ch0[SAMPLE_BITS-1:0];
    assign w_b[1] = i_b_ch1[SAMPLE_BITS-1:0];
    assign w_b[2] = i_b_ch2[SAMPLE_BITS-1:0];

    for (genvar g = 0; g < LANES; g++) begin : g_sq
        assign w_asq[g] = w_a[g] * w_a[g];
        assign w_bsq[g] = w_b[g] * w_b[g];
    end

    // statistics and fit state
    logic [1:0]              r_cfg_act;
    logic [SUM_W-1:0]        r_sum_ref [LANES];
    logic [SUM_W-1:0]        r_sum_src [LANES];
    logic [SQ_W-1:0]         r_sq_ref  [LANES];
    logic [SQ_W-1:0]         r_sq_src  [LANES];
    logic [CNT_W-1:0]        r_count;
    logic [GAIN_W-1:0]       r_gain    [LANES];
    logic signed [OFF_W-1:0] r_off     [LANES];
    logic                    r_map_ready;
    t_fit_st                 r_fit_st;

    logic [CH_W-1:0] w_act;
    logic            w_take_acc, w_take_clr, w_take_map, w_acc_ok;

    always_comb begin
        if (r_cfg_act == 2'd0) begin
            w_act = 2'd1;
        end else if (r_cfg_act > CH_W'(NCH)) begin
            w_act = CH_W'(NCH);
        end else begin
            w_act = r_cfg_act;
        end
    end

    assign w_take_acc = i_cmd.take && (t_req'(i_req_type) == REQ_ACC);
    assign w_take_clr = i_cmd.take && (t_req'(i_req_type) == REQ_CLR);
    assign w_take_map = i_cmd.take && (t_req'(i_req_type) == REQ_MAP);
    assign w_acc_ok   = w_take_acc && i_pixel_valid &&
                        (LIM_W'(r_count) < LIM_W'(MAX_PIXELS)) && (r_count < CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_act <= 2'd3;
        end else if (i_cfg_we) begin
            r_cfg_act <= i_cfg_wdata;
        end
    end

    // iterative engine
    t_op               r_op;
    logic [CH_W-1:0]   r_ch;
    logic              r_side;
    logic              r_busy, r_fin, r_done;
    logic [STEP_W-1:0] r_cnt, r_last;
    logic [PROD_W-1:0] r_mcand, r_acc;
    logic [MPLR_W-1:0] r_mplier;
    logic [P1_W-1:0]   r_p1;
    logic [D_W-1:0]    r_d, r_sv;
    logic [ROOT_W-1:0] r_root, r_sa, r_sb;
    logic [SREM_W-1:0] r_srem;
    logic [NUM_W-1:0]  r_num, r_q, r_mag;
    logic [DVS_W-1:0]  r_dvs, r_drem;
    logic              r_negf;

    logic [SREM_W+1:0] w_st, w_trial;
    logic [DVS_W:0]    w_dt;
    logic [NUM_W-1:0]  w_pos, w_neg;
    logic [SUM_W-1:0]  w_sum_sel;
    logic [SQ_W-1:0]   w_sq_sel;

    assign w_st      = {r_srem, r_sv[D_W-1 -: 2]};
    assign w_trial   = (SREM_W+2)'({r_root, 2'b01});
    assign w_dt      = {r_drem, r_num[NUM_W-1]};
    assign w_pos     = NUM_W'({r_sum_ref[r_ch], {GAIN_FRAC_BITS{1'b0}}});
    assign w_neg     = r_acc[NUM_W-1:0];
    assign w_sum_sel = i_cmd.side_ref ? r_sum_ref[i_cmd.ch] : r_sum_src[i_cmd.ch];
    assign w_sq_sel  = i_cmd.side_ref ? r_sq_ref[i_cmd.ch]  : r_sq_src[i_cmd.ch];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_cnt == r_last);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == r_last)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_ch   <= i_cmd.ch;
            r_side <= i_cmd.side_ref;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_root <= '0;
            r_srem <= '0;
            r_q    <= '0;
            r_drem <= '0;
            case (i_cmd.op)
                OP_MUL_NSQ: begin
                    r_mcand  <= PROD_W'(w_sq_sel);
                    r_mplier <= MPLR_W'(r_count);
                    r_last   <= STEP_W'(MPLR_W - 1);
                end
                OP_MUL_SS: begin
                    r_mcand  <= PROD_W'(w_sum_sel);
                    r_mplier <= MPLR_W'(w_sum_sel);
                    r_last   <= STEP_W'(MPLR_W - 1);
                end
                OP_MUL_GS: begin
                    r_mcand  <= PROD_W'(r_gain[i_cmd.ch]);
                    r_mplier <= MPLR_W'(r_sum_src[i_cmd.ch]);
                    r_last   <= STEP_W'(MPLR_W - 1);
                end
                OP_SQRT: begin
                    r_sv   <= r_d;
                    r_last <= STEP_W'(ROOT_W - 1);
                end
                OP_DIV_G: begin
                    r_num  <= NUM_W'({r_sa, {GAIN_FRAC_BITS{1'b0}}}) + NUM_W'(r_sb >> 1);
                    r_dvs  <= DVS_W'(r_sb);
                    r_last <= STEP_W'(NUM_W - 1);
                end
                OP_DIV_O: begin
                    r_num  <= r_mag;
                    r_dvs  <= DVS_W'(r_count);
                    r_last <= STEP_W'(NUM_W - 1);
                end
                default: r_last <= '0;
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            case (r_op) inside
                OP_MUL_NSQ, OP_MUL_SS, OP_MUL_GS: begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
                OP_SQRT: begin
                    // one root bit per step, restoring
                    r_sv <= r_sv << 2;
                    if (w_st >= w_trial) begin
                        r_srem <= SREM_W'(w_st - w_trial);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= SREM_W'(w_st);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                end
                OP_DIV_G, OP_DIV_O: begin
                    r_num <= r_num << 1;
                    if (w_dt >= {1'b0, r_dvs}) begin
                        r_drem <= DVS_W'(w_dt - {1'b0, r_dvs});
                        r_q    <= {r_q[NUM_W-2:0], 1'b1};
                    end else begin
                        r_drem <= DVS_W'(w_dt);
                        r_q    <= {r_q[NUM_W-2:0], 1'b0};
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end else if (r_fin) begin
            case (r_op)
                OP_MUL_NSQ: r_p1 <= r_acc[P1_W-1:0];
                OP_MUL_SS: begin
                    // negative spread clamps to zero
                    r_d <= (r_p1 > r_acc[P1_W-1:0]) ? D_W'(r_p1 - r_acc[P1_W-1:0]) : '0;
                end
                OP_SQRT: begin
                    if (r_side) r_sa <= r_root;
                    else        r_sb <= r_root;
                end
                OP_MUL_GS: begin
                    r_negf <= (w_pos < w_neg);
                    r_mag  <= ((w_pos < w_neg) ? (w_neg - w_pos) : (w_pos - w_neg)) +
                              NUM_W'(r_count >> 1);
                end
                default: r_negf <= r_negf;
            endcase
        end
    end

    // offset saturation and sign
    logic [NUM_W-1:0] w_omag;
    assign w_omag = r_negf ? ((r_q > OFFLIM) ? OFFLIM : r_q)
                           : ((r_q > OFFLIM - 1'b1) ? OFFLIM - 1'b1 : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_take_clr) begin
            for (int l = 0; l < LANES; l++) begin
                r_sum_ref[l] <= '0;
                r_sum_src[l] <= '0;
                r_sq_ref[l]  <= '0;
                r_sq_src[l]  <= '0;
                r_gain[l]    <= GONE;
                r_off[l]     <= '0;
            end
            r_count     <= '0;
            r_map_ready <= 1'b0;
            r_fit_st    <= ST_OK;
        end else begin
            if (w_acc_ok) begin
                for (int l = 0; l < LANES; l++) begin
                    r_sum_ref[l] <= r_sum_ref[l] + SUM_W'(w_a[l]);
                    r_sum_src[l] <= r_sum_src[l] + SUM_W'(w_b[l]);
                    r_sq_ref[l]  <= r_sq_ref[l] + SQ_W'(w_asq[l]);
                    r_sq_src[l]  <= r_sq_src[l] + SQ_W'(w_bsq[l]);
                end
                r_count     <= r_count + 1'b1;
                r_map_ready <= 1'b0;
            end
            if (i_cmd.fit_init) begin
                for (int l = 0; l < LANES; l++) begin
                    r_gain[l] <= GONE;
                    r_off[l]  <= '0;
                end
                r_map_ready <= 1'b1;
                r_fit_st    <= (r_count == '0) ? ST_EMPTY : ST_OK;
            end
            if (i_cmd.set_flat) r_fit_st <= ST_FLAT;
            if (r_fin && (r_op == OP_DIV_G)) begin
                r_gain[r_ch] <= (|r_q[NUM_W-1:GAIN_W]) ? '1 : r_q[GAIN_W-1:0];
            end
            if (r_fin && (r_op == OP_DIV_O)) begin
                r_off[r_ch] <= r_negf ? -$signed(OFF_W'(w_omag)) : $signed(OFF_W'(w_omag));
            end
        end
    end

    // map: product stage, then offset, rounding and saturation
    logic [SAMPLE_BITS-1:0] r_b    [LANES];
    logic [MAPP_W-1:0]      r_prod [LANES];
    logic [MAPP_W-1:0]      w_prod [LANES];
    logic [V_W-1:0]         w_v    [LANES];
    logic [V_W-2-GAIN_FRAC_BITS:0] w_hi [LANES];
    logic [SAMPLE_BITS-1:0] w_res  [LANES];
    logic                   w_clip;

    for (genvar g = 0; g < LANES; g++) begin : g_map
        assign w_prod[g] = r_gain[g] * r_b[g];
        assign w_v[g]    = V_W'(r_prod[g]) +
                           {{(V_W-OFF_W){r_off[g][OFF_W-1]}}, r_off[g]} + VHALF;
        assign w_hi[g]   = w_v[g][V_W-2:GAIN_FRAC_BITS];
    end

    always_comb begin
        w_clip = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            w_res[l] = '0;
            if (CH_W'(l) < w_act) begin
                if (w_v[l][V_W-1]) begin
                    w_clip = 1'b1;
                end else if (w_hi[l] > (V_W-1-GAIN_FRAC_BITS)'(SMASK)) begin
                    w_res[l] = SMASK;
                    w_clip   = 1'b1;
                end else begin
                    w_res[l] = w_hi[l][SAMPLE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_map) begin
            for (int l = 0; l < LANES; l++) r_b[l] <= w_b[l];
        end
        if (i_cmd.map_mul) begin
            for (int l = 0; l < LANES; l++) r_prod[l] <= w_prod[l];
        end
        if (i_cmd.out_load) begin
            o_out_ch0    <= 16'(w_res[0]);
            o_out_ch1    <= 16'(w_res[1]);
            o_out_ch2    <= 16'(w_res[2]);
            o_map_status <= r_fit_st;
            o_clipped    <= w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.map_ready = r_map_ready;
    assign o_stat.n_zero    = (r_count == '0);
    assign o_stat.sb_zero   = (r_sb == '0);
    assign o_stat.act       = w_act;
    assign o_stat.out_busy  = o_out_valid && !i_out_ready;

endmodule

`default_nettype wire

@@ rtl/mstc_chk.sv @@
// Port-level checks for mean_std_color_transfer, bound to the top level.
// Depends on mstc_pkg.
`default_nettype none

module mstc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_ch0,
    input logic [15:0] o_out_ch1,
    input logic [15:0] o_out_ch2,
    input logic [1:0]  o_map_status,
    input logic        o_clipped
);
    import mstc_pkg::*;

    // a pending result is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // accepting a map transaction always takes the block out of idle
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_MAP) |=> !o_in_ready)
        else $error("map accepted back to back");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_map_status <= ST_FLAT))
        else $error("bad map status");

    // saturation leaves at least one channel at a rail
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            (o_out_ch0 == 16'd0 || o_out_ch0 == 16'hFFFF ||
             o_out_ch1 == 16'd0 || o_out_ch1 == 16'hFFFF ||
             o_out_ch2 == 16'd0 || o_out_ch2 == 16'hFFFF))
        else $error("clip flag without rail value");

endmodule

bind mean_std_color_transfer mstc_chk u_mstc_chk (.*);

`default_nettype wire
